// ----- sv/sws_pkg.sv -----
`timescale 1ns / 1ps

package sws_pkg;

	// Sequence space and payload width are fixed by the field widths.
	localparam int SEQ_MODULUS  = 16;
	localparam int SEQ_W        = 4;
	localparam int PAYLOAD_BITS = 64;
	localparam int LIMIT_W      = 4;
	localparam int THRESH_W     = 3;
	localparam int KIND_W       = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 4;

	// Request kinds.
	localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_LIMIT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUP_THRESHOLD = 2'd1;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0]  WINDOW_LIMIT_RST  = 4'd8;
	localparam logic [THRESH_W-1:0] DUP_THRESHOLD_RST = 3'd4;

	// The duplicate counter saturates here.
	localparam logic [THRESH_W-1:0] DUP_MAX = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_W-1:0]        ack_number;
		logic                    checksum_ok;
	} sws_cmd_t;

	typedef struct packed {
		logic                    accepted;
		logic                    pkt_valid;
		logic                    pkt_is_retransmit;
		logic [SEQ_W-1:0]        pkt_seq;
		logic [PAYLOAD_BITS-1:0] pkt_payload;
		logic                    timer_stop;
		logic                    timer_start;
		logic [SEQ_W-1:0]        timer_seq;
		logic                    window_full;
	} sws_rsp_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]  window_limit;
		logic [THRESH_W-1:0] dup_threshold;
	} sws_cfg_t;

endpackage

// ----- sv/sws_if.sv -----
`timescale 1ns / 1ps

interface sws_cmd_if;
	logic             valid;
	logic             ready;
	sws_pkg::sws_cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sws_rsp_if;
	logic             valid;
	logic             ready;
	sws_pkg::sws_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sws_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [sws_pkg::CFG_INDEX_W-1:0]    index;
	logic [sws_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/sws_store.sv -----
`timescale 1ns / 1ps

// Payload ring: one write port, one registered read port.
module sws_store #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [$clog2(WINDOW_DEPTH)-1:0]  wr_addr,
	input  logic [sws_pkg::PAYLOAD_BITS-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [$clog2(WINDOW_DEPTH)-1:0]  rd_addr,
	output logic [sws_pkg::PAYLOAD_BITS-1:0] rd_data
);

	logic [sws_pkg::PAYLOAD_BITS-1:0] mem [WINDOW_DEPTH];
	logic [sws_pkg::PAYLOAD_BITS-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ----- sv/sws_core.sv -----
`timescale 1ns / 1ps

// Window state and the per-request decision logic.
module sws_core #(
	parameter int WINDOW_DEPTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  sws_pkg::sws_cmd_t                item,
	input  sws_pkg::sws_cfg_t                cfg_regs,
	output sws_pkg::sws_rsp_t                res,
	output logic                             wr_en,
	output logic [$clog2(WINDOW_DEPTH)-1:0]  wr_addr,
	output logic [sws_pkg::PAYLOAD_BITS-1:0] wr_data,
	output logic [$clog2(WINDOW_DEPTH)-1:0]  rd_addr
);

	localparam int IDX_W   = $clog2(WINDOW_DEPTH);
	localparam int SUM_W   = ((IDX_W > sws_pkg::SEQ_W) ? IDX_W : sws_pkg::SEQ_W) + 1;
	localparam int LIM_MAX = (WINDOW_DEPTH < sws_pkg::SEQ_MODULUS - 1) ?
		WINDOW_DEPTH : sws_pkg::SEQ_MODULUS - 1;

	logic [sws_pkg::SEQ_W-1:0]    base_q, next_q, last_ack_q;
	logic [sws_pkg::THRESH_W-1:0] dup_q;
	logic                         last_ack_valid_q;
	logic [IDX_W-1:0]             head_q;

	logic [sws_pkg::SEQ_W-1:0]    base_n, next_n, last_ack_n;
	logic [sws_pkg::THRESH_W-1:0] dup_n, dup_inc;
	logic                         last_ack_valid_n;
	logic [IDX_W-1:0]             head_n, slot;

	logic [sws_pkg::SEQ_W-1:0] lim, cnt, cnt_n, ack_span;
	logic [SUM_W-1:0]          slot_sum, head_sum;
	logic                      send_ok, retx;

	always_comb begin
		lim = (cfg_regs.window_limit > sws_pkg::SEQ_W'(LIM_MAX)) ?
			sws_pkg::SEQ_W'(LIM_MAX) : cfg_regs.window_limit;
		cnt      = next_q - base_q;
		ack_span = item.ack_number - base_q;

		// Both sums stay below twice the depth, so one subtract wraps them.
		slot_sum = SUM_W'(head_q) + SUM_W'(cnt);
		slot = (slot_sum >= SUM_W'(WINDOW_DEPTH)) ?
			IDX_W'(slot_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(slot_sum);
		head_sum = SUM_W'(head_q) + SUM_W'(ack_span);

		dup_inc = (dup_q == sws_pkg::DUP_MAX) ? dup_q : dup_q + 3'd1;

		base_n           = base_q;
		next_n           = next_q;
		head_n           = head_q;
		dup_n            = dup_q;
		last_ack_n       = last_ack_q;
		last_ack_valid_n = last_ack_valid_q;
		send_ok          = 1'b0;
		retx             = 1'b0;
		res              = '0;
		cnt_n            = cnt;

		unique case (item.kind)
			sws_pkg::KIND_SEND: begin
				if (cnt < lim) begin
					send_ok               = 1'b1;
					res.accepted          = 1'b1;
					res.pkt_valid         = 1'b1;
					res.pkt_seq           = next_q;
					res.pkt_payload       = item.payload;
					res.timer_start       = (cnt == '0);
					next_n                = next_q + 4'd1;
				end
			end
			sws_pkg::KIND_ACK: begin
				if (item.checksum_ok) begin
					res.timer_stop = 1'b1;
					// Cumulative ack inside the window slides the base.
					if (ack_span != '0 && ack_span <= cnt) begin
						base_n = item.ack_number;
						head_n = (head_sum >= SUM_W'(WINDOW_DEPTH)) ?
							IDX_W'(head_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(head_sum);
					end
					if (last_ack_valid_q && item.ack_number == last_ack_q) begin
						dup_n = dup_inc;
					end else begin
						dup_n = '0;
					end
					last_ack_n       = item.ack_number;
					last_ack_valid_n = 1'b1;
					cnt_n            = next_q - base_n;
					if (cnt_n != '0) begin
						res.timer_start = 1'b1;
						retx = (dup_n >= cfg_regs.dup_threshold);
					end
				end
			end
			sws_pkg::KIND_TIMEOUT: begin
				res.timer_stop  = 1'b1;
				res.timer_start = 1'b1;
				retx            = (cnt != '0);
			end
			default: begin
			end
		endcase

		// Payload of a retransmission is read from the store and joined to the registered response.
		if (retx) begin
			res.pkt_valid         = 1'b1;
			res.pkt_is_retransmit = 1'b1;
			res.pkt_seq           = base_n;
		end
		res.timer_seq   = base_n;
		res.window_full = ((next_n - base_n) >= lim);
	end

	assign wr_en   = step && send_ok;
	assign wr_addr = slot;
	assign wr_data = item.payload;
	assign rd_addr = head_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q           <= '0;
			next_q           <= '0;
			head_q           <= '0;
			dup_q            <= '0;
			last_ack_q       <= '0;
			last_ack_valid_q <= 1'b0;
		end else if (step) begin
			base_q           <= base_n;
			next_q           <= next_n;
			head_q           <= head_n;
			dup_q            <= dup_n;
			last_ack_q       <= last_ack_n;
			last_ack_valid_q <= last_ack_valid_n;
		end
	end

endmodule

// ----- sv/sliding_window_sender.sv -----
// Sender side of a sliding window with cumulative acknowledgements and fast
// retransmit. Requests arrive on cmd: a send carries a payload, an ack carries
// the receiver's cumulative ack number and a checksum flag, and a timeout
// reports expiry of the retransmit timer. Every request produces exactly one
// response on rsp, which says whether a send entered the window, which packet
// (new or retransmitted) goes to the network, and how to drive the timer.
// cfg writes the window limit (index 0) and the duplicate ack threshold
// (index 1); it is always ready and is to be used only while the block idles.
// A request passes an input register and then a result register, which offers
// the response on rsp. One request is taken every cycle while rsp is not stalled,
// as the whole decision is one short step of pointer arithmetic and a single
// payload memory access between those two registers.
// When rsp is stalled the result register holds its response and the input
// register can still take one more request; only then does cmd.ready fall.
// Reset empties the window, forgets the last ack and restores the register
// defaults (limit 8, threshold 4). The payload memory is not cleared, as only
// slots written by accepted sends are ever read back.
`timescale 1ns / 1ps

module sliding_window_sender #(
	parameter int WINDOW_DEPTH = 8
) (
	input logic            clk,
	input logic            arst_n,
	sws_cfg_if.sink        cfg,
	sws_cmd_if.sink        cmd,
	sws_rsp_if.source      rsp
);

	localparam int IDX_W = $clog2(WINDOW_DEPTH);

	// Configuration registers.
	sws_pkg::sws_cfg_t cfg_q;

	// Input stage and result stage.
	logic              s1_valid;
	sws_pkg::sws_cmd_t item_s1;
	logic              rsp_valid_q;
	sws_pkg::sws_rsp_t res_q;

	sws_pkg::sws_rsp_t res_n;
	sws_pkg::sws_rsp_t rsp_data;
	logic              advance, step, cmd_take;

	logic                             wr_en;
	logic [IDX_W-1:0]                 wr_addr, rd_addr;
	logic [sws_pkg::PAYLOAD_BITS-1:0] wr_data, rd_data;

	// The result register moves whenever it is empty or being drained; the
	// input register empties into it on the same edge.
	assign advance   = !rsp_valid_q || rsp.ready;
	assign step      = s1_valid && advance;
	assign cmd.ready = !s1_valid || advance;
	assign cmd_take  = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_limit  <= sws_pkg::WINDOW_LIMIT_RST;
			cfg_q.dup_threshold <= sws_pkg::DUP_THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sws_pkg::CFG_WINDOW_LIMIT: begin
					cfg_q.window_limit <= cfg.data[sws_pkg::LIMIT_W-1:0];
				end
				sws_pkg::CFG_DUP_THRESHOLD: begin
					cfg_q.dup_threshold <= cfg.data[sws_pkg::THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_take) begin
				s1_valid <= 1'b1;
			end else if (step) begin
				s1_valid <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= s1_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			item_s1 <= cmd.data;
		end
		if (step) begin
			res_q <= res_n;
		end
	end

	sws_core #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.item     (item_s1),
		.cfg_regs (cfg_q),
		.res      (res_n),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr  (rd_addr)
	);

	// The oldest slot is read on the same edge that loads the result
	// register, so its data lines up with the registered response.
	sws_store #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (step),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		rsp_data = res_q;
		if (res_q.pkt_is_retransmit) begin
			rsp_data.pkt_payload = rd_data;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data;

	// An accepted send always emits a fresh packet.
	a_send_emits: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.accepted |->
			rsp.data.pkt_valid && !rsp.data.pkt_is_retransmit)
		else $error("accepted send without a fresh packet");

	// Every retransmission comes with a timer restart.
	a_retx_timer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.pkt_is_retransmit |-> rsp.data.timer_start)
		else $error("retransmission without timer restart");

	// A request held in the input stage is not dropped while the output stalls.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid && $stable(item_s1))
		else $error("input stage lost a request during a stall");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	// Slot count of the payload ring; the block is built with its default depth.
	localparam int SLOT_COUNT = 8;

	// Request kind with no meaning to the block: it must change nothing.
	localparam logic [sws_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	sws_cmd_if cmd_bus ();
	sws_rsp_if rsp_bus ();
	sws_cfg_if cfg_bus ();

	sliding_window_sender DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.cmd    (cmd_bus),
		.rsp    (rsp_bus)
	);

	// Requests waiting to be offered on cmd, and the responses that the window model
	// has worked out for requests that the block has already taken, oldest first.
	sws_pkg::sws_cmd_t pending_req_q [$];
	sws_pkg::sws_rsp_t expected_rsp_q [$];

	// Percentage of cycles in which the request side or the response side holds back.
	int unsigned send_gap_pct;
	int unsigned recv_gap_pct;

	int unsigned errors;
	int unsigned n_new_pkts;
	int unsigned n_resent;
	int unsigned n_refused;
	int unsigned n_checked;

	// Window model: sequence pointers, the duplicate ack run, the last ack seen, the ring
	// of stored payloads and the two programmable registers.
	logic [sws_pkg::SEQ_W-1:0]        win_base;
	logic [sws_pkg::SEQ_W-1:0]        win_next;
	logic [sws_pkg::THRESH_W-1:0]     dup_run;
	logic [sws_pkg::SEQ_W-1:0]        prev_ack;
	logic                             prev_ack_seen;
	logic [2:0]                       ring_head;
	logic [sws_pkg::PAYLOAD_BITS-1:0] slot_mem [SLOT_COUNT];
	logic [sws_pkg::LIMIT_W-1:0]      limit_cfg;
	logic [sws_pkg::THRESH_W-1:0]     thresh_cfg;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Safety net: a healthy run needs well under a tenth of this.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Works out the response to one accepted request and moves the window model on.
	// The outstanding count is simply the 4-bit difference of the two pointers, and
	// the limit is clamped to the ring depth, so a limit of zero refuses every send.
	function automatic sws_pkg::sws_rsp_t predict_response(input sws_pkg::sws_cmd_t req);
		sws_pkg::sws_rsp_t           want;
		logic [sws_pkg::SEQ_W-1:0]   in_flight;
		logic [sws_pkg::SEQ_W-1:0]   advance;
		logic [sws_pkg::LIMIT_W-1:0] cap;
		logic                        resend;
		want = '0;
		resend = 1'b0;
		cap = (limit_cfg > sws_pkg::LIMIT_W'(SLOT_COUNT)) ?
			sws_pkg::LIMIT_W'(SLOT_COUNT) : limit_cfg;
		in_flight = win_next - win_base;
		case (req.kind)
			sws_pkg::KIND_SEND: begin
				if (in_flight < cap) begin
					slot_mem[ring_head + in_flight[2:0]] = req.payload;
					want.accepted = 1'b1;
					want.pkt_valid = 1'b1;
					want.pkt_seq = win_next;
					want.pkt_payload = req.payload;
					// The timer only starts on the first packet into an empty window.
					want.timer_start = (in_flight == 0);
					win_next = win_next + 1'b1;
					n_new_pkts++;
				end else begin
					n_refused++;
				end
			end
			sws_pkg::KIND_ACK: begin
				// An ack that failed its checksum is dropped without any effect.
				if (req.checksum_ok) begin
					want.timer_stop = 1'b1;
					advance = req.ack_number - win_base;
					if (advance >= 1 && advance <= in_flight) begin
						win_base = req.ack_number;
						ring_head = ring_head + advance[2:0];
					end
					// Repeats of the same ack number count up and stick at the maximum,
					// whether or not the ack moved the window.
					if (prev_ack_seen && req.ack_number == prev_ack) begin
						if (dup_run != sws_pkg::DUP_MAX)
							dup_run = dup_run + 1'b1;
					end else begin
						dup_run = '0;
					end
					prev_ack = req.ack_number;
					prev_ack_seen = 1'b1;
					in_flight = win_next - win_base;
					if (in_flight != 0) begin
						want.timer_start = 1'b1;
						resend = (dup_run >= thresh_cfg);
					end
				end
			end
			sws_pkg::KIND_TIMEOUT: begin
				// The timer is always restarted, but an empty window has nothing to resend.
				want.timer_stop = 1'b1;
				want.timer_start = 1'b1;
				resend = (in_flight != 0);
			end
			default: begin
			end
		endcase
		if (resend) begin
			want.pkt_valid = 1'b1;
			want.pkt_is_retransmit = 1'b1;
			want.pkt_seq = win_base;
			want.pkt_payload = slot_mem[ring_head];
			n_resent++;
		end
		want.timer_seq = win_base;
		want.window_full = ((win_next - win_base) >= cap);
		return want;
	endfunction

	function automatic void push_req(input logic [sws_pkg::KIND_W-1:0] kind,
			input logic [sws_pkg::PAYLOAD_BITS-1:0] payload,
			input logic [sws_pkg::SEQ_W-1:0] ack, input logic ok);
		sws_pkg::sws_cmd_t req;
		req.kind = kind;
		req.payload = payload;
		req.ack_number = ack;
		req.checksum_ok = ok;
		pending_req_q = {pending_req_q, req};
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Register writes happen only while the block is idle, so the model's copy of the
	// register may be updated as soon as the write handshake completes.
	task automatic write_reg(input logic [sws_pkg::CFG_INDEX_W-1:0] idx,
			input logic [sws_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == sws_pkg::CFG_WINDOW_LIMIT)
			limit_cfg = val;
		else if (idx == sws_pkg::CFG_DUP_THRESHOLD)
			thresh_cfg = val[sws_pkg::THRESH_W-1:0];
	endtask

	// Every request yields exactly one response, so the block is idle once nothing is
	// queued, nothing is on offer and no response is outstanding. The check is made
	// at the falling edge, where the driver's updates have all settled.
	task automatic wait_idle();
		while (pending_req_q.size() != 0 || expected_rsp_q.size() != 0 || cmd_bus.valid)
			@(negedge clk);
	endtask

	// Request driver: a request stays on offer until it is taken, and the model
	// predicts its response at the very edge at which the block takes it.
	always @(posedge clk or negedge arst_n) begin : cmd_driver
		sws_pkg::sws_rsp_t want_now;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.data <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				want_now = predict_response(cmd_bus.data);
				expected_rsp_q = {expected_rsp_q, want_now};
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (pending_req_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					cmd_bus.valid <= 1'b1;
					cmd_bus.data <= pending_req_q[0];
					pending_req_q.delete(0);
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: compares each response taken with the oldest prediction and
	// stalls the block at random.
	always @(posedge clk or negedge arst_n) begin : rsp_monitor
		sws_pkg::sws_rsp_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_rsp_q.size() == 0) begin
					$display("%0t: response mismatch, expected none, actual %h", $time,
						rsp_bus.data);
					errors++;
				end else begin
					want = expected_rsp_q[0];
					expected_rsp_q.delete(0);
					n_checked++;
					check_field("accepted", 64'(want.accepted),
						64'(rsp_bus.data.accepted));
					check_field("pkt_valid", 64'(want.pkt_valid),
						64'(rsp_bus.data.pkt_valid));
					check_field("pkt_is_retransmit", 64'(want.pkt_is_retransmit),
						64'(rsp_bus.data.pkt_is_retransmit));
					check_field("pkt_seq", 64'(want.pkt_seq),
						64'(rsp_bus.data.pkt_seq));
					check_field("pkt_payload", want.pkt_payload, rsp_bus.data.pkt_payload);
					check_field("timer_stop", 64'(want.timer_stop),
						64'(rsp_bus.data.timer_stop));
					check_field("timer_start", 64'(want.timer_start),
						64'(rsp_bus.data.timer_start));
					check_field("timer_seq", 64'(want.timer_seq),
						64'(rsp_bus.data.timer_seq));
					check_field("window_full", 64'(want.window_full),
						64'(rsp_bus.data.window_full));
				end
			end
			rsp_bus.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
		end
	end

	// Stimulus. After a directed pass at the default settings, six random phases each
	// program a new limit and threshold. The idling pattern moves from a slow sender
	// with a slower receiver, to the reverse, to full rate on both sides.
	initial begin
		int unsigned                      seg_limit [6];
		int unsigned                      seg_thresh [6];
		int unsigned                      seg_items [6];
		int unsigned                      made;
		int unsigned                      roll;
		int unsigned                      burst;
		logic [sws_pkg::PAYLOAD_BITS-1:0] data_word;
		logic [sws_pkg::SEQ_W-1:0]        ack;
		logic [sws_pkg::SEQ_W-1:0]        span;
		logic                             ok;

		// Limits of zero, one, fifteen and nine (clamped to the ring depth) sit beside
		// ordinary ones; thresholds run from zero, where no duplicate is needed, to seven.
		seg_limit = '{1, 15, 8, 0, 4, 9};
		seg_thresh = '{0, 7, 1, 3, 2, 5};
		seg_items = '{240, 240, 240, 60, 260, 240};

		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		errors = 0;
		n_new_pkts = 0;
		n_resent = 0;
		n_refused = 0;
		n_checked = 0;
		send_gap_pct = 21;
		recv_gap_pct = 66;
		win_base = '0;
		win_next = '0;
		dup_run = '0;
		prev_ack = '0;
		prev_ack_seen = 1'b0;
		ring_head = '0;
		limit_cfg = sws_pkg::WINDOW_LIMIT_RST;
		thresh_cfg = sws_pkg::DUP_THRESHOLD_RST;

		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(sws_pkg::CFG_WINDOW_LIMIT, sws_pkg::WINDOW_LIMIT_RST);
		write_reg(sws_pkg::CFG_DUP_THRESHOLD,
			sws_pkg::CFG_DATA_W'(sws_pkg::DUP_THRESHOLD_RST));

		// Directed pass. Fill the window with extreme payloads and have one send
		// refused, drop an ack with a bad checksum, then repeat one ack until the
		// fast retransmit fires and the duplicate counter saturates. Then an unused
		// kind, a timeout with packets outstanding, an ack that empties the window,
		// a timeout and a repeated ack on an empty window, and an ack outside it.
		@(negedge clk);
		push_req(sws_pkg::KIND_SEND, '0, '0, 1'b0);
		push_req(sws_pkg::KIND_SEND, '1, '1, 1'b1);
		repeat (6) push_req(sws_pkg::KIND_SEND, {$urandom, $urandom},
			sws_pkg::SEQ_W'($urandom), 1'b0);
		push_req(sws_pkg::KIND_SEND, {$urandom, $urandom}, '0, 1'b1);
		push_req(sws_pkg::KIND_ACK, {$urandom, $urandom}, 4'd1, 1'b0);
		repeat (9) push_req(sws_pkg::KIND_ACK, {$urandom, $urandom}, 4'd1, 1'b1);
		push_req(KIND_UNUSED, '1, '1, 1'b1);
		push_req(sws_pkg::KIND_TIMEOUT, {$urandom, $urandom}, '0, 1'b0);
		push_req(sws_pkg::KIND_ACK, {$urandom, $urandom}, 4'd8, 1'b1);
		push_req(sws_pkg::KIND_TIMEOUT, '0, '1, 1'b1);
		push_req(sws_pkg::KIND_ACK, {$urandom, $urandom}, 4'd8, 1'b1);
		push_req(sws_pkg::KIND_ACK, {$urandom, $urandom}, 4'd12, 1'b1);

		for (int seg = 0; seg < 6; seg++) begin
			wait_idle();
			@(negedge clk);
			case (seg / 2)
				0: begin
					send_gap_pct = 21;
					recv_gap_pct = 66;
				end
				1: begin
					send_gap_pct = 66;
					recv_gap_pct = 21;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			write_reg(sws_pkg::CFG_WINDOW_LIMIT, sws_pkg::CFG_DATA_W'(seg_limit[seg]));
			write_reg(sws_pkg::CFG_DUP_THRESHOLD, sws_pkg::CFG_DATA_W'(seg_thresh[seg]));

			// Requests are made just in time at the falling edge, so that acks can
			// aim at the window as it stands. Most traffic is sends and acks inside
			// the window, with runs of duplicate acks to reach the threshold; the rest
			// is random acks, timeouts and the unused kind.
			made = 0;
			while (made < seg_items[seg]) begin
				@(negedge clk);
				if (pending_req_q.size() < 2) begin
					roll = $urandom_range(0, 99);
					data_word = {$urandom, $urandom};
					if ($urandom_range(0, 15) == 0)
						data_word = $urandom_range(0, 1) ? '1 : '0;
					ack = sws_pkg::SEQ_W'($urandom_range(0, 15));
					ok = 1'($urandom_range(0, 1));
					span = win_next - win_base;
					if (roll < 45) begin
						push_req(sws_pkg::KIND_SEND, data_word, ack, ok);
						made++;
					end else if (roll < 60) begin
						push_req(sws_pkg::KIND_ACK, data_word,
							win_base + sws_pkg::SEQ_W'($urandom_range(0, span)), 1'b1);
						made++;
					end else if (roll < 70) begin
						burst = $urandom_range(2, 9);
						ack = prev_ack_seen ? prev_ack : win_base;
						repeat (burst) push_req(sws_pkg::KIND_ACK, data_word, ack, 1'b1);
						made += burst;
					end else if (roll < 82) begin
						push_req(sws_pkg::KIND_ACK, data_word, ack, ok);
						made++;
					end else if (roll < 95) begin
						push_req(sws_pkg::KIND_TIMEOUT, data_word, ack, ok);
						made++;
					end else begin
						push_req(KIND_UNUSED, data_word, ack, ok);
						made++;
					end
				end
			end
		end

		// Two register stages lie between request and response, so the wait after the
		// last response is enough to catch anything spurious.
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Checked %0d responses over seven register settings and three idling patterns.",
			n_checked);
		$display("Model saw %0d new packets, %0d retransmissions and %0d refused sends.",
			n_new_pkts, n_resent, n_refused);
		if (errors == 0 && expected_rsp_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- sliding_window_sender.f -----
sv/sws_pkg.sv
sv/sws_if.sv
sv/sws_store.sv
sv/sws_core.sv
sv/sliding_window_sender.sv
sim/testbench.sv
